/* rtl/nps_pkg.sv */
package nps_pkg;

	// table size and coordinate width
	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 16;

	// derived widths
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int MAG_W  = COORD_BITS;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 1;

	// fixed widths of the result fields
	localparam int IDX_FIELD_W  = 10;
	localparam int DIST_FIELD_W = 34;
	localparam int CNT_FIELD_W  = 11;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// what the output register is loaded with
	typedef enum logic [2:0] {
		OUT_CLEAR,
		OUT_INSERT,
		OUT_FULL,
		OUT_EMPTY,
		OUT_NOP,
		OUT_QUERY
	} out_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic     clear;
		logic     insert;
		logic     start_scan;
		logic     scan_read;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic scan_last;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

/* rtl/nps_req_if.sv */
interface nps_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [nps_pkg::OP_W-1:0]              op;
	logic signed [nps_pkg::COORD_BITS-1:0] point_x;
	logic signed [nps_pkg::COORD_BITS-1:0] point_y;

	modport source (output valid, output op, output point_x, output point_y, input ready);
	modport sink (input valid, input op, input point_x, input point_y, output ready);
endinterface

/* rtl/nps_rsp_if.sv */
interface nps_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [nps_pkg::IDX_FIELD_W-1:0]   entry_index;
	logic [nps_pkg::DIST_FIELD_W-1:0]  squared_distance;
	logic [nps_pkg::STATUS_W-1:0]      status;
	logic [nps_pkg::CNT_FIELD_W-1:0]   entry_count;

	modport source (output valid, output entry_index, output squared_distance,
		output status, output entry_count, input ready);
	modport sink (input valid, input entry_index, input squared_distance,
		input status, input entry_count, output ready);
endinterface

/* rtl/nps_ctrl.sv */
module nps_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic [nps_pkg::OP_W-1:0] op,
	output logic                     req_ready,
	input  nps_pkg::sts_t            sts,
	output nps_pkg::cmd_t            cmd
);

	nps_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd            = '0;
		cmd.out_sel    = nps_pkg::OUT_NOP;
		unique case (state_q)
			nps_pkg::ST_IDLE: begin
				req_ready = sts.out_free;
				if (req_valid && sts.out_free) begin
					unique case (op)
						nps_pkg::OP_CLEAR: begin
							cmd.clear    = 1'b1;
							cmd.out_load = 1'b1;
							cmd.out_sel  = nps_pkg::OUT_CLEAR;
						end
						nps_pkg::OP_INSERT: begin
							cmd.out_load = 1'b1;
							if (sts.full) begin
								cmd.out_sel = nps_pkg::OUT_FULL;
							end else begin
								cmd.insert  = 1'b1;
								cmd.out_sel = nps_pkg::OUT_INSERT;
							end
						end
						nps_pkg::OP_QUERY: begin
							if (sts.count_zero) begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = nps_pkg::OUT_EMPTY;
							end else begin
								cmd.start_scan = 1'b1;
								state_d        = nps_pkg::ST_SCAN;
							end
						end
						default: begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = nps_pkg::OUT_NOP;
						end
					endcase
				end
			end
			nps_pkg::ST_SCAN: begin
				cmd.scan_read = 1'b1;
				if (sts.scan_last) begin
					state_d = nps_pkg::ST_DRAIN;
				end
			end
			nps_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = nps_pkg::OUT_QUERY;
					state_d      = nps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/nps_datapath.sv */
module nps_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [nps_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [nps_pkg::COORD_BITS-1:0] point_y,
	input  nps_pkg::cmd_t                         cmd,
	output nps_pkg::sts_t                         sts,
	nps_rsp_if.source                             rsp
);

	localparam int C = nps_pkg::COORD_BITS;

	// point table, x in the upper half
	logic [2*C-1:0] mem [nps_pkg::MAX_POINTS];

	logic [nps_pkg::CNT_W-1:0]  count_q;
	logic [nps_pkg::ADDR_W-1:0] addr_q;
	logic signed [C-1:0]        qx_q, qy_q;

	// scan pipeline
	logic                       v_s1, v_s2, v_s3;
	logic [nps_pkg::ADDR_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [2*C-1:0]             rd_s1;
	logic [nps_pkg::SQ_W-1:0]   sqx_s2, sqy_s2;
	logic [nps_pkg::SUM_W-1:0]  sum_s3;

	logic                       first_q;
	logic [nps_pkg::ADDR_W-1:0] best_idx_q;
	logic [nps_pkg::SUM_W-1:0]  best_d_q;

	logic                       out_valid_q;
	logic [nps_pkg::IDX_FIELD_W-1:0]  out_idx_q;
	logic [nps_pkg::DIST_FIELD_W-1:0] out_dist_q;
	nps_pkg::status_t                 out_status_q;
	logic [nps_pkg::CNT_FIELD_W-1:0]  out_cnt_q;

	logic signed [C:0]          dx, dy;
	logic [nps_pkg::MAG_W-1:0]  mx, my;
	logic [nps_pkg::CNT_W-1:0]  count_inc;

	// width fitting to the result fields
	logic [nps_pkg::ADDR_W+nps_pkg::IDX_FIELD_W-1:0]  fit_best_idx, fit_ins_idx;
	logic [nps_pkg::CNT_W+nps_pkg::CNT_FIELD_W-1:0]   fit_cnt, fit_cnt_inc;
	logic [nps_pkg::SUM_W+nps_pkg::DIST_FIELD_W-1:0]  fit_dist;

	assign count_inc = count_q + 1'b1;

	assign sts.count_zero = (count_q == '0);
	assign sts.full       = (count_q >= nps_pkg::CNT_W'(nps_pkg::MAX_POINTS));
	assign sts.scan_last  = ({1'b0, addr_q} == nps_pkg::CNT_W'(count_q - 1'b1));
	assign sts.pipe_busy  = v_s1 | v_s2 | v_s3;
	assign sts.out_free   = !out_valid_q || rsp.ready;

	// table and count
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			mem[count_q[nps_pkg::ADDR_W-1:0]] <= {point_x, point_y};
		end
		if (cmd.scan_read) begin
			rd_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_inc;
		end
	end

	// query point and scan address
	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			qx_q   <= point_x;
			qy_q   <= point_y;
			addr_q <= '0;
		end else if (cmd.scan_read) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// absolute differences
	always_comb begin
		dx = $signed({rd_s1[2*C-1], rd_s1[2*C-1:C]}) - $signed({qx_q[C-1], qx_q});
		dy = $signed({rd_s1[C-1], rd_s1[C-1:0]}) - $signed({qy_q[C-1], qy_q});
		mx = dx[C] ? nps_pkg::MAG_W'(-dx) : nps_pkg::MAG_W'(dx);
		my = dy[C] ? nps_pkg::MAG_W'(-dy) : nps_pkg::MAG_W'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_read;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		sqx_s2 <= mx * mx;
		sqy_s2 <= my * my;
		sum_s3 <= nps_pkg::SUM_W'(sqx_s2) + nps_pkg::SUM_W'(sqy_s2);
	end

	// running minimum, first hit wins ties
	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			first_q <= 1'b1;
		end else if (v_s3) begin
			first_q <= 1'b0;
			if (first_q || (sum_s3 < best_d_q)) begin
				best_d_q   <= sum_s3;
				best_idx_q <= idx_s3;
			end
		end
	end

	assign fit_best_idx = {{nps_pkg::IDX_FIELD_W{1'b0}}, best_idx_q};
	assign fit_ins_idx  = {{nps_pkg::IDX_FIELD_W{1'b0}}, count_q[nps_pkg::ADDR_W-1:0]};
	assign fit_cnt      = {{nps_pkg::CNT_FIELD_W{1'b0}}, count_q};
	assign fit_cnt_inc  = {{nps_pkg::CNT_FIELD_W{1'b0}}, count_inc};
	assign fit_dist     = {{nps_pkg::DIST_FIELD_W{1'b0}}, best_d_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_idx_q    <= '0;
			out_dist_q   <= '0;
			out_status_q <= nps_pkg::STATUS_OK;
			out_cnt_q    <= fit_cnt[nps_pkg::CNT_FIELD_W-1:0];
			unique case (cmd.out_sel)
				nps_pkg::OUT_CLEAR: begin
					out_cnt_q <= '0;
				end
				nps_pkg::OUT_INSERT: begin
					out_idx_q <= fit_ins_idx[nps_pkg::IDX_FIELD_W-1:0];
					out_cnt_q <= fit_cnt_inc[nps_pkg::CNT_FIELD_W-1:0];
				end
				nps_pkg::OUT_FULL: begin
					out_status_q <= nps_pkg::STATUS_FULL;
				end
				nps_pkg::OUT_EMPTY: begin
					out_status_q <= nps_pkg::STATUS_EMPTY;
				end
				nps_pkg::OUT_QUERY: begin
					out_idx_q  <= fit_best_idx[nps_pkg::IDX_FIELD_W-1:0];
					out_dist_q <= fit_dist[nps_pkg::DIST_FIELD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.entry_index      = out_idx_q;
	assign rsp.squared_distance = out_dist_q;
	assign rsp.status           = out_status_q;
	assign rsp.entry_count      = out_cnt_q;

endmodule

/* rtl/nearest_point_search.sv */
// channel  dir  handshake     payload
// req      in   valid/ready   op, point_x, point_y
// rsp      out  valid/ready   entry_index, squared_distance, status, entry_count
//
// clear, insert, unused op and query on an empty table: the result is loaded as the request is taken
// query: the table is scanned one point a cycle through its single read port, and each point
// passes the read, square and sum stages into the running minimum before the output load
// arst_n clears the point count, the controller and the valid flags; the table is not cleared
// a new request is taken only while the controller idles and the output register is free
// or being emptied in the same cycle; a stalled result holds the scan's end in drain
module nearest_point_search (
	input  logic      clk,
	input  logic      arst_n,
	nps_req_if.sink   req,
	nps_rsp_if.source rsp
);

	nps_pkg::cmd_t cmd;
	nps_pkg::sts_t sts;
	logic          ctl_ready;

	// request side handshake comes from the controller
	assign req.ready = ctl_ready;

	// sequencer: decodes each request and walks the table during a query
	nps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.op        (req.op),
		.req_ready (ctl_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table memory, distance pipeline, running minimum and output register
	nps_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.point_x (req.point_x),
		.point_y (req.point_y),
		.cmd     (cmd),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule
